### rtl/euler_zyx_point_rotation_defines.svh
// assertion macros for the rtl, included by ezr_cordic
`ifndef EULER_ZYX_POINT_ROTATION_DEFINES_SVH
`define EULER_ZYX_POINT_ROTATION_DEFINES_SVH

// same-cycle implication
`define EZR_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EZR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ezr_pkg.sv
`timescale 1ns / 1ps
package ezr_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int ANGLE_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_COUNT    = 24;
   localparam int TRIG_FRAC     = 30;
   localparam int TRIG_WIDTH    = 34;
   localparam int PHASE_WIDTH   = 32;
   localparam int Z_WIDTH       = 34;
   localparam int PROD_WIDTH    = 2 * TRIG_WIDTH;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN_INV = TRIG_WIDTH'(652032874);

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic signed [ANGLE_WIDTH-1:0] yaw_angle;
      logic signed [ANGLE_WIDTH-1:0] pitch_angle;
      logic signed [ANGLE_WIDTH-1:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rotated_x;
      logic signed [COORD_WIDTH-1:0] rotated_y;
      logic signed [COORD_WIDTH-1:0] rotated_z;
      logic                          clipped;
   } rsp_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // atan(2^-i) as a fraction of a full turn, 2^32 per turn
   function automatic logic [PHASE_WIDTH-1:0] atan_phase(input int idx);
      logic [PHASE_WIDTH-1:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   // round half up and drop the trig fraction of a raw product
   function automatic trig_type mulq(input prod_type prod);
      prod_type t;
      t = prod + (prod_type'(1) <<< (TRIG_FRAC - 1));
      return t[TRIG_FRAC +: TRIG_WIDTH];
   endfunction

endpackage

### rtl/euler_zyx_point_rotation.sv
`timescale 1ns / 1ps
// ZYX Euler rotation of a Q16.16 point, fully pipelined: a beat is taken on
// every cycle that start is high, busy never rises, and each beat comes out
// on rsp_strobe in order. The three angle CORDICs run min(CORDIC_STAGES, 24)
// iterations (one register stage per iteration); the matrix build and the dot
// products add four stages each. The result is shown for one cycle only and
// must be taken then.
module euler_zyx_point_rotation #(
   parameter int CORDIC_STAGES = ezr_pkg::CORDIC_STAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ezr_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ezr_pkg::rsp_type rsp_data
);
   import ezr_pkg::*;

   logic            accept;
   logic            cor_valid;
   trig_type [2:0]  cor_cos, cor_sin;
   coord_type [2:0] cor_pt;
   logic            mat_valid;
   trig_type [8:0]  mat;
   coord_type [2:0] mat_pt;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   ezr_cordic #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (cor_valid),
      .cos_out   (cor_cos),
      .sin_out   (cor_sin),
      .point_out (cor_pt)
   );

   ezr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .cos_in    (cor_cos),
      .sin_in    (cor_sin),
      .point_in  (cor_pt),
      .out_valid (mat_valid),
      .mat_out   (mat),
      .point_out (mat_pt)
   );

   ezr_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .mat_in    (mat),
      .point_in  (mat_pt),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

### rtl/ezr_cordic.sv
`timescale 1ns / 1ps
`include "euler_zyx_point_rotation_defines.svh"
module ezr_cordic #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  ezr_pkg::req_type           in_data,
   output logic                       out_valid,
   output ezr_pkg::trig_type [2:0]    cos_out,
   output ezr_pkg::trig_type [2:0]    sin_out,
   output ezr_pkg::coord_type [2:0]   point_out
);
   import ezr_pkg::*;

   localparam int NS = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;
   localparam int TW = TRIG_WIDTH;
   localparam int ZW = Z_WIDTH;
   localparam int PW = PHASE_WIDTH;
   localparam logic signed [ZW-1:0] Z_BOUND = ZW'(1) <<< (PW - 3);
   localparam logic signed [TW-1:0] TRIG_BOUND =
      (TW'(1) <<< TRIG_FRAC) + (TW'(1) <<< (TRIG_FRAC - 6));

   logic signed [TW-1:0] x_ff [0:NS][0:2];
   logic signed [TW-1:0] x_in [0:NS][0:2];
   logic signed [TW-1:0] y_ff [0:NS][0:2];
   logic signed [TW-1:0] y_in [0:NS][0:2];
   logic signed [ZW-1:0] z_ff [0:NS][0:2];
   logic signed [ZW-1:0] z_in [0:NS][0:2];
   logic [2:0]           flip_ff [0:NS];
   logic [2:0]           flip_in [0:NS];
   coord_type [2:0]      pt_ff [0:NS];
   coord_type [2:0]      pt_in [0:NS];
   logic [NS:0]          valid_ff;
   logic [NS:0]          valid_in;

   trig_type [2:0]  cos_ff, cos_in, sin_ff, sin_in;
   coord_type [2:0] pout_ff, pout_in;
   logic            vout_ff, vout_in;

   logic signed [ANGLE_WIDTH-1:0] ang [0:2];
   logic [PW-1:0]                 phase [0:2];
   logic [PW-1:0]                 phase_r [0:2];
   logic [2:0]                    flip;

   always_comb begin
      ang[0] = in_data.yaw_angle;
      ang[1] = in_data.pitch_angle;
      ang[2] = in_data.roll_angle;
      for (int l = 0; l < 3; l++) begin
         phase[l] = {ang[l], {(PW - ANGLE_WIDTH){1'b0}}};
         // second and third quarter: move by a half turn, negate at the end
         flip[l] = phase[l][PW-1] ^ phase[l][PW-2];
         phase_r[l] = flip[l] ? (phase[l] ^ {1'b1, {(PW - 1){1'b0}}}) : phase[l];
         x_in[0][l] = CORDIC_GAIN_INV;
         y_in[0][l] = '0;
         z_in[0][l] = ZW'($signed(phase_r[l]));
      end
      flip_in[0]  = flip;
      pt_in[0]    = {in_data.point_z, in_data.point_y, in_data.point_x};
      valid_in[0] = in_valid;

      for (int s = 0; s < NS; s++) begin
         for (int l = 0; l < 3; l++) begin
            if (!z_ff[s][l][ZW-1]) begin
               x_in[s+1][l] = x_ff[s][l] - (y_ff[s][l] >>> s);
               y_in[s+1][l] = y_ff[s][l] + (x_ff[s][l] >>> s);
               z_in[s+1][l] = z_ff[s][l] - ZW'($signed({1'b0, atan_phase(s)}));
            end else begin
               x_in[s+1][l] = x_ff[s][l] + (y_ff[s][l] >>> s);
               y_in[s+1][l] = y_ff[s][l] - (x_ff[s][l] >>> s);
               z_in[s+1][l] = z_ff[s][l] + ZW'($signed({1'b0, atan_phase(s)}));
            end
         end
         flip_in[s+1]  = flip_ff[s];
         pt_in[s+1]    = pt_ff[s];
         valid_in[s+1] = valid_ff[s];
      end

      for (int l = 0; l < 3; l++) begin
         cos_in[l] = flip_ff[NS][l] ? -x_ff[NS][l] : x_ff[NS][l];
         sin_in[l] = flip_ff[NS][l] ? -y_ff[NS][l] : y_ff[NS][l];
      end
      pout_in = pt_ff[NS];
      vout_in = valid_ff[NS];
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= NS; s++) begin
         for (int l = 0; l < 3; l++) begin
            x_ff[s][l] <= x_in[s][l];
            y_ff[s][l] <= y_in[s][l];
            z_ff[s][l] <= z_in[s][l];
         end
         flip_ff[s] <= flip_in[s];
         pt_ff[s]   <= pt_in[s];
      end
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      pout_ff <= pout_in;
      if (reset) begin
         valid_ff <= '0;
         vout_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vout_ff  <= vout_in;
      end
   end

   assign out_valid = vout_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign point_out = pout_ff;

   `EZR_ASSERT(a_phase_converged, clock, reset, valid_ff[NS], (z_ff[NS][0] <= Z_BOUND) && (z_ff[NS][0] >= -Z_BOUND) && (z_ff[NS][1] <= Z_BOUND) && (z_ff[NS][1] >= -Z_BOUND) && (z_ff[NS][2] <= Z_BOUND) && (z_ff[NS][2] >= -Z_BOUND), "cordic residual phase out of range")
   `EZR_ASSERT(a_trig_bounded, clock, reset, vout_ff, (cos_ff[1] <= TRIG_BOUND) && (cos_ff[1] >= -TRIG_BOUND) && (sin_ff[1] <= TRIG_BOUND) && (sin_ff[1] >= -TRIG_BOUND), "pitch sine or cosine beyond unit magnitude")
   `EZR_ASSERT_NEXT(a_valid_follows, clock, reset, valid_ff[NS], vout_ff, "cordic output beat lost")

endmodule

### rtl/ezr_matrix.sv
`timescale 1ns / 1ps
module ezr_matrix (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ezr_pkg::trig_type [2:0]   cos_in,
   input  ezr_pkg::trig_type [2:0]   sin_in,
   input  ezr_pkg::coord_type [2:0]  point_in,
   output logic                      out_valid,
   output ezr_pkg::trig_type [8:0]   mat_out,
   output ezr_pkg::coord_type [2:0]  point_out
);
   import ezr_pkg::*;

   // lanes: 0 yaw, 1 pitch, 2 roll
   trig_type ca, sa, cb, sb, cc, sc;
   assign ca = cos_in[0];
   assign sa = sin_in[0];
   assign cb = cos_in[1];
   assign sb = sin_in[1];
   assign cc = cos_in[2];
   assign sc = sin_in[2];

   prod_type [9:0]  p1_ff, p1_in;
   trig_type        nsb1_ff, cc1_ff, sc1_ff;
   trig_type [9:0]  q2_ff, q2_in;
   trig_type        nsb2_ff, cc2_ff, sc2_ff;
   prod_type [3:0]  t3_ff, t3_in;
   trig_type [9:2]  q3_ff;
   trig_type        nsb3_ff;
   trig_type [8:0]  m4_ff, m4_in;
   coord_type [2:0] pt1_ff, pt2_ff, pt3_ff, pt4_ff;
   logic [3:0]      valid_ff;

   always_comb begin
      p1_in[0] = prod_type'(ca) * prod_type'(sb);
      p1_in[1] = prod_type'(sa) * prod_type'(sb);
      p1_in[2] = prod_type'(ca) * prod_type'(cb);
      p1_in[3] = prod_type'(sa) * prod_type'(cb);
      p1_in[4] = prod_type'(sa) * prod_type'(cc);
      p1_in[5] = prod_type'(ca) * prod_type'(cc);
      p1_in[6] = prod_type'(sa) * prod_type'(sc);
      p1_in[7] = prod_type'(ca) * prod_type'(sc);
      p1_in[8] = prod_type'(cb) * prod_type'(sc);
      p1_in[9] = prod_type'(cb) * prod_type'(cc);

      for (int k = 0; k < 10; k++) begin
         q2_in[k] = mulq(p1_ff[k]);
      end

      t3_in[0] = prod_type'(q2_ff[0]) * prod_type'(sc2_ff);
      t3_in[1] = prod_type'(q2_ff[0]) * prod_type'(cc2_ff);
      t3_in[2] = prod_type'(q2_ff[1]) * prod_type'(sc2_ff);
      t3_in[3] = prod_type'(q2_ff[1]) * prod_type'(cc2_ff);

      m4_in[0] = q3_ff[2];
      m4_in[1] = mulq(t3_ff[0]) - q3_ff[4];
      m4_in[2] = mulq(t3_ff[1]) + q3_ff[6];
      m4_in[3] = q3_ff[3];
      m4_in[4] = mulq(t3_ff[2]) + q3_ff[5];
      m4_in[5] = mulq(t3_ff[3]) - q3_ff[7];
      m4_in[6] = nsb3_ff;
      m4_in[7] = q3_ff[8];
      m4_in[8] = q3_ff[9];
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      nsb1_ff <= -sb;
      cc1_ff  <= cc;
      sc1_ff  <= sc;
      pt1_ff  <= point_in;
      q2_ff   <= q2_in;
      nsb2_ff <= nsb1_ff;
      cc2_ff  <= cc1_ff;
      sc2_ff  <= sc1_ff;
      pt2_ff  <= pt1_ff;
      t3_ff   <= t3_in;
      q3_ff   <= q2_ff[9:2];
      nsb3_ff <= nsb2_ff;
      pt3_ff  <= pt2_ff;
      m4_ff   <= m4_in;
      pt4_ff  <= pt3_ff;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[3];
   assign mat_out   = m4_ff;
   assign point_out = pt4_ff;

endmodule

### rtl/ezr_dot.sv
`timescale 1ns / 1ps
module ezr_dot (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ezr_pkg::trig_type [8:0]   mat_in,
   input  ezr_pkg::coord_type [2:0]  point_in,
   output logic                      out_valid,
   output ezr_pkg::rsp_type          out_data
);
   import ezr_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int TW   = TRIG_WIDTH;
   localparam int LO_W = CW / 2;
   localparam int HI_W = CW - LO_W;
   localparam int PH_W = TW + HI_W;
   localparam int PL_W = TW + LO_W + 1;
   localparam int SH_W = PH_W + 2;
   localparam int SL_W = PL_W + 2;
   localparam int SW   = TW + CW + 3;
   localparam int VW   = SW - TRIG_FRAC;
   localparam logic signed [VW-1:0] MAXV = {{(VW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
   localparam logic signed [VW-1:0] MINV = ~MAXV;
   localparam logic signed [SW-1:0] ROUND = SW'(1) <<< (TRIG_FRAC - 1);

   logic signed [HI_W-1:0]  ph [0:2];
   logic signed [LO_W:0]    pl [0:2];
   logic signed [PH_W-1:0]  mh_ff [0:8];
   logic signed [PH_W-1:0]  mh_in [0:8];
   logic signed [PL_W-1:0]  ml_ff [0:8];
   logic signed [PL_W-1:0]  ml_in [0:8];
   logic signed [SH_W-1:0]  sh_ff [0:2];
   logic signed [SH_W-1:0]  sh_in [0:2];
   logic signed [SL_W-1:0]  sl_ff [0:2];
   logic signed [SL_W-1:0]  sl_in [0:2];
   logic signed [SW-1:0]    s_full [0:2];
   logic signed [VW-1:0]    v_ff [0:2];
   logic signed [VW-1:0]    v_in [0:2];
   coord_type [2:0]         sat;
   logic [2:0]              clip;
   rsp_type                 res_ff, res_in;
   logic [3:0]              valid_ff;

   always_comb begin
      // point split into a signed upper part and an unsigned lower part
      for (int j = 0; j < 3; j++) begin
         ph[j] = point_in[j][CW-1:LO_W];
         pl[j] = $signed({1'b0, point_in[j][LO_W-1:0]});
      end
      for (int k = 0; k < 9; k++) begin
         mh_in[k] = PH_W'(mat_in[k]) * PH_W'(ph[k % 3]);
         ml_in[k] = PL_W'(mat_in[k]) * PL_W'(pl[k % 3]);
      end
      for (int r = 0; r < 3; r++) begin
         sh_in[r] = SH_W'(mh_ff[3*r]) + SH_W'(mh_ff[3*r+1]) + SH_W'(mh_ff[3*r+2]);
         sl_in[r] = SL_W'(ml_ff[3*r]) + SL_W'(ml_ff[3*r+1]) + SL_W'(ml_ff[3*r+2]);
         s_full[r] = (SW'(sh_ff[r]) <<< LO_W) + SW'(sl_ff[r]) + ROUND;
         v_in[r] = s_full[r][SW-1:TRIG_FRAC];
         if (v_ff[r] > MAXV) begin
            sat[r]  = {1'b0, {(CW - 1){1'b1}}};
            clip[r] = 1'b1;
         end else if (v_ff[r] < MINV) begin
            sat[r]  = {1'b1, {(CW - 1){1'b0}}};
            clip[r] = 1'b1;
         end else begin
            sat[r]  = v_ff[r][CW-1:0];
            clip[r] = 1'b0;
         end
      end
      res_in.rotated_x = sat[0];
      res_in.rotated_y = sat[1];
      res_in.rotated_z = sat[2];
      res_in.clipped   = |clip;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         mh_ff[k] <= mh_in[k];
         ml_ff[k] <= ml_in[k];
      end
      for (int r = 0; r < 3; r++) begin
         sh_ff[r] <= sh_in[r];
         sl_ff[r] <= sl_in[r];
         v_ff[r]  <= v_in[r];
      end
      res_ff <= res_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = res_ff;

endmodule
